FILE: src/rtpm_pkg.sv
// ----------------------------------------------------------------------------
// rtpm_pkg: shared types and constants for the route table
// Word layouts, table geometry, kind and status codes, and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpm_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KIND_W        = 2;
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int PLEN_W        = 6;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_INDEX_W = 6;

  localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESOLVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IP_W-1:0]   ip_addr;
    logic [IP_W-1:0]   prefix_mask;
    logic [MAC_W-1:0]  station_mac;
    logic [MAC_W-1:0]  next_hop_mac_in;
    logic              broadcast;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [MAC_W-1:0]         next_hop_mac;
  } out_item_t;

  typedef struct packed {
    logic [IP_W-1:0]   addr;
    logic [IP_W-1:0]   mask;
    logic [PLEN_W-1:0] plen;
    logic [MAC_W-1:0]  station_mac;
    logic [MAC_W-1:0]  next_hop;
  } route_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    route_entry_t     wr_data;
  } mem_req_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_RESP
  } ctrl_state_t;

  // Population count as a balanced adder tree.
  function automatic logic [PLEN_W-1:0] mask_popcount(input logic [IP_W-1:0] m);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  // Table index as it appears in the result word.
  function automatic logic [ENTRY_INDEX_W-1:0] idx_field(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[ENTRY_INDEX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/rtpm_table_mem.sv
// ----------------------------------------------------------------------------
// rtpm_table_mem: route entry storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpm_table_mem
  import rtpm_pkg::*;
(
  input  wire logic         clk,
  input  wire mem_req_t     req,
  output route_entry_t      rd_data_r
);

  route_entry_t mem_q [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_q[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_q[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/rtpm_ctrl.sv
// ----------------------------------------------------------------------------
// rtpm_ctrl: scan sequencer for the route table
// Streams the valid entries out of the table memory one a cycle and runs the
// exact match, longest-prefix match or station search on each as it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpm_ctrl
  import rtpm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire in_item_t     in_data,
  output mem_req_t          mem_req,
  input  wire route_entry_t rd_data,
  output logic              res_valid,
  output out_item_t         res,
  input  wire logic         res_take
);

  ctrl_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   issue_idx_r, issue_idx_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [PLEN_W-1:0]    best_len_r, best_len_nxt;
  logic [MAC_W-1:0]     best_nh_r, best_nh_nxt;
  in_item_t             item_r, item_nxt;
  logic [PLEN_W-1:0]    plen_r, plen_nxt;
  out_item_t            res_r, res_nxt;

  logic hit;
  logic lpm;
  logic issue_done;

  assign res = res_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    rd_pend_nxt   = rd_pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_len_nxt  = best_len_r;
    best_nh_nxt   = best_nh_r;
    item_nxt      = item_r;
    plen_nxt      = plen_r;
    res_nxt       = res_r;
    mem_req       = '0;
    in_stall      = (state_r != CS_IDLE);
    res_valid     = (state_r == CS_RESP);
    issue_done    = (issue_idx_r == count_r);

    hit = 1'b0;
    if (rd_pend_r) begin
      if (item_r.kind == KIND_UPDATE) begin
        hit = (rd_data.addr == item_r.ip_addr) && (rd_data.mask == item_r.prefix_mask);
      end else if (item_r.kind == KIND_FIND) begin
        hit = (rd_data.station_mac == item_r.station_mac);
      end
    end
    lpm = rd_pend_r && (item_r.kind == KIND_RESOLVE) &&
          (((rd_data.addr ^ item_r.ip_addr) & rd_data.mask) == '0);

    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_data;
          plen_nxt      = mask_popcount(in_data.prefix_mask);
          issue_idx_nxt = '0;
          rd_pend_nxt   = 1'b0;
          found_nxt     = 1'b0;
          best_idx_nxt  = '0;
          best_len_nxt  = '0;
          best_nh_nxt   = '0;
          res_nxt       = '0;
          if (in_data.kind == KIND_RESOLVE && in_data.broadcast) begin
            res_nxt.status       = STAT_OK;
            res_nxt.next_hop_mac = MAC_BCAST;
            state_nxt            = CS_RESP;
          end else if (in_data.kind == KIND_UNUSED) begin
            res_nxt.status = STAT_MISS;
            state_nxt      = CS_RESP;
          end else begin
            state_nxt = CS_SCAN;
          end
        end
      end

      CS_SCAN: begin
        // Keep one read in flight; the word read last cycle is judged now.
        if (!issue_done) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = issue_idx_r[IDX_W-1:0];
          issue_idx_nxt   = issue_idx_r + 1'b1;
          rd_pend_nxt     = 1'b1;
          cmp_idx_nxt     = issue_idx_r[IDX_W-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
        end

        // Ties keep the earlier route: only a strictly longer prefix replaces it.
        if (lpm && (!found_r || best_len_r < rd_data.plen)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_len_nxt = rd_data.plen;
          best_nh_nxt  = rd_data.next_hop;
        end

        priority if (hit) begin
          if (item_r.kind == KIND_UPDATE) begin
            mem_req.wr_en                = 1'b1;
            mem_req.wr_addr              = cmp_idx_r;
            mem_req.wr_data              = rd_data;
            mem_req.wr_data.station_mac  = item_r.station_mac;
            mem_req.wr_data.next_hop     = item_r.next_hop_mac_in;
          end
          res_nxt.status       = STAT_OK;
          res_nxt.entry_index  = idx_field(cmp_idx_r);
          res_nxt.next_hop_mac = '0;
          state_nxt            = CS_RESP;
        end else if (issue_done && !rd_pend_r) begin
          res_nxt = '0;
          if (item_r.kind == KIND_UPDATE) begin
            if (count_r == COUNT_W'(TABLE_DEPTH)) begin
              res_nxt.status = STAT_FULL;
            end else begin
              mem_req.wr_en                = 1'b1;
              mem_req.wr_addr              = count_r[IDX_W-1:0];
              mem_req.wr_data.addr         = item_r.ip_addr;
              mem_req.wr_data.mask         = item_r.prefix_mask;
              mem_req.wr_data.plen         = plen_r;
              mem_req.wr_data.station_mac  = item_r.station_mac;
              mem_req.wr_data.next_hop     = item_r.next_hop_mac_in;
              count_nxt                    = count_r + 1'b1;
              res_nxt.status               = STAT_OK;
              res_nxt.entry_index          = idx_field(count_r[IDX_W-1:0]);
            end
          end else if (item_r.kind == KIND_RESOLVE && found_r) begin
            res_nxt.status       = STAT_OK;
            res_nxt.entry_index  = idx_field(best_idx_r);
            res_nxt.next_hop_mac = best_nh_r;
          end else begin
            res_nxt.status = STAT_MISS;
          end
          state_nxt = CS_RESP;
        end else begin
          state_nxt = CS_SCAN;
        end
      end

      CS_RESP: begin
        if (res_take) begin
          state_nxt = CS_IDLE;
        end
      end

      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CS_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r <= issue_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_len_r  <= best_len_nxt;
    best_nh_r   <= best_nh_nxt;
    item_r      <= item_nxt;
    plen_r      <= plen_nxt;
    res_r       <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(TABLE_DEPTH))
    else $error("route count exceeds table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1 && $past(state_r) == CS_SCAN))
    else $error("route count moved other than by one append");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == CS_SCAN && !(in_valid && !in_stall)))
    else $error("table written outside a scan");

  a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_SCAN && mem_req.rd_en) |=> rd_pend_r)
    else $error("issued read not tracked");

  a_resp_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_r.status == STAT_OK || res_r.status == STAT_MISS ||
                   res_r.status == STAT_FULL))
    else $error("result carries an undefined status");

endmodule

`default_nettype wire

FILE: src/route_table_prefix_match.sv
// ----------------------------------------------------------------------------
// route_table_prefix_match: routing table with longest-prefix next-hop lookup
// A scan reads the routes through the single read port of the table memory,
// streaming one entry a cycle; update and find stop on a hit, resolve runs to
// the end, and a broadcast resolve or an unused kind skips the scan. The table
// holds at most 64 routes. A new word is taken only once the last result has
// moved to the output register. Reset empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none

module route_table_prefix_match
  import rtpm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  mem_req_t      mem_req;
  route_entry_t  rd_data;
  logic          res_valid;
  out_item_t     res;
  logic          res_take;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  rtpm_table_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_data)
  );

  rtpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register frees the sequencer as soon as a word is parked here.
  always_comb begin
    res_take      = res_valid && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for route_table_prefix_match
// Sends update, resolve and find words through the valid/stall handshake and
// keeps a shadow copy of the route table to predict each answer. Every result
// word is checked in order against the predictions. Both sides idle and stall
// at random, and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import rtpm_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 80;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow of the route table, updated as each word is accepted.
  int               route_total = 0;
  logic [IP_W-1:0]  shadow_addr     [TABLE_DEPTH];
  logic [IP_W-1:0]  shadow_mask     [TABLE_DEPTH];
  int               shadow_plen     [TABLE_DEPTH];
  logic [MAC_W-1:0] shadow_station  [TABLE_DEPTH];
  logic [MAC_W-1:0] shadow_next_hop [TABLE_DEPTH];

  // Network bases that random routes share, so that prefixes overlap.
  logic [IP_W-1:0]  net_base [8];

  out_item_t answer_q [$];
  int        fault_count = 0;
  int        idle_cycles = 0;
  bit        gaps_on     = 1'b1;
  bit        hold_go     = 1'b0;

  route_table_prefix_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_item_t compute_route_answer(input in_item_t w);
    out_item_t a;
    int        i;
    int        best;
    a        = '0;
    a.status = STAT_MISS;
    case (w.kind)
      KIND_UPDATE: begin
        for (i = 0; i < route_total; i++) begin
          if (shadow_addr[i] == w.ip_addr && shadow_mask[i] == w.prefix_mask) begin
            shadow_station[i]  = w.station_mac;
            shadow_next_hop[i] = w.next_hop_mac_in;
            a.status      = STAT_OK;
            a.entry_index = ENTRY_INDEX_W'(i);
            return a;
          end
        end
        if (route_total >= TABLE_DEPTH) begin
          a.status = STAT_FULL;
          return a;
        end
        shadow_addr[route_total]     = w.ip_addr;
        shadow_mask[route_total]     = w.prefix_mask;
        shadow_plen[route_total]     = $countones(w.prefix_mask);
        shadow_station[route_total]  = w.station_mac;
        shadow_next_hop[route_total] = w.next_hop_mac_in;
        a.status      = STAT_OK;
        a.entry_index = ENTRY_INDEX_W'(route_total);
        route_total++;
      end
      KIND_RESOLVE: begin
        if (w.broadcast) begin
          a.status       = STAT_OK;
          a.next_hop_mac = MAC_BCAST;
        end else begin
          // The earliest route keeps a tie; only a strictly longer prefix wins.
          best = -1;
          for (i = 0; i < route_total; i++) begin
            if ((shadow_addr[i] & shadow_mask[i]) == (w.ip_addr & shadow_mask[i]) &&
                (best < 0 || shadow_plen[best] < shadow_plen[i])) begin
              best = i;
            end
          end
          if (best >= 0) begin
            a.status       = STAT_OK;
            a.entry_index  = ENTRY_INDEX_W'(best);
            a.next_hop_mac = shadow_next_hop[best];
          end
        end
      end
      KIND_FIND: begin
        for (i = 0; i < route_total; i++) begin
          if (shadow_station[i] == w.station_mac) begin
            a.status      = STAT_OK;
            a.entry_index = ENTRY_INDEX_W'(i);
            return a;
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic in_item_t route_word(input logic [KIND_W-1:0] kind,
                                          input logic [IP_W-1:0] ip,
                                          input logic [IP_W-1:0] mask,
                                          input logic [MAC_W-1:0] smac,
                                          input logic [MAC_W-1:0] nhop,
                                          input logic bcast);
    in_item_t w;
    w.kind            = kind;
    w.ip_addr         = ip;
    w.prefix_mask     = mask;
    w.station_mac     = smac;
    w.next_hop_mac_in = nhop;
    w.broadcast       = bcast;
    return w;
  endfunction

  function automatic logic [MAC_W-1:0] any_mac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAC_BCAST;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [IP_W-1:0] mask_of_len(input int plen);
    return (plen == 0) ? '0 : ({IP_W{1'b1}} << (IP_W - plen));
  endfunction

  function automatic in_item_t random_route_word();
    in_item_t w;
    int       pick;
    int       k;
    int       j;
    w.kind            = KIND_UNUSED;
    w.ip_addr         = $urandom;
    w.prefix_mask     = $urandom;
    w.station_mac     = any_mac();
    w.next_hop_mac_in = any_mac();
    w.broadcast       = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    k    = (route_total > 0) ? $urandom_range(0, route_total - 1) : 0;
    j    = $urandom_range(0, 7);
    if (pick < 35) begin
      w.kind = KIND_UPDATE;
      if (route_total > 0 && $urandom_range(0, 4) == 0) begin
        w.ip_addr     = shadow_addr[k];
        w.prefix_mask = shadow_mask[k];
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          w.prefix_mask = mask_of_len($urandom_range(0, 32));
        end
        if ($urandom_range(0, 4) != 0) begin
          w.ip_addr = {net_base[j][31:16], w.ip_addr[15:0]};
        end
        if (route_total > 0 && $urandom_range(0, 5) == 0) begin
          w.station_mac = shadow_station[k];
        end
      end
    end else if (pick < 80) begin
      w.kind      = KIND_RESOLVE;
      w.broadcast = ($urandom_range(0, 9) == 0);
      if (route_total > 0 && $urandom_range(0, 3) != 0) begin
        w.ip_addr = (shadow_addr[k] & shadow_mask[k]) | (w.ip_addr & ~shadow_mask[k]);
      end else if ($urandom_range(0, 1) == 1) begin
        w.ip_addr = {net_base[j][31:16], w.ip_addr[15:0]};
      end
    end else if (pick < 95) begin
      w.kind = KIND_FIND;
      if (route_total > 0 && $urandom_range(0, 3) != 0) begin
        w.station_mac = shadow_station[k];
      end
    end
    return w;
  endfunction

  // An update whose address and mask are not yet in the table, so it appends unless the table is full.
  function automatic in_item_t fresh_route_word();
    in_item_t w;
    bit       taken;
    int       i;
    int       j;
    w      = random_route_word();
    w.kind = KIND_UPDATE;
    do begin
      j             = $urandom_range(0, 7);
      w.ip_addr     = {net_base[j][31:16], 16'($urandom)};
      w.prefix_mask = mask_of_len($urandom_range(8, 32));
      taken         = 1'b0;
      for (i = 0; i < route_total; i++) begin
        if (shadow_addr[i] == w.ip_addr && shadow_mask[i] == w.prefix_mask) begin
          taken = 1'b1;
        end
      end
    end while (taken);
    return w;
  endfunction

  task automatic push_word(input in_item_t w);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    answer_q.push_back(compute_route_answer(w));
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (answer_q.size() == 0) begin
        note_fault($sformatf("result word with nothing pending: %p", out_data));
      end else begin
        want = answer_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.entry_index !== want.entry_index ||
            out_data.next_hop_mac !== want.next_hop_mac) begin
          note_fault($sformatf(
            "status %0d got %0d, index %0d got %0d, next hop %h got %h",
            want.status, out_data.status, want.entry_index, out_data.entry_index,
            want.next_hop_mac, out_data.next_hop_mac));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver pacing: short random stalls, or one long hold-off on request.
  initial begin : result_pacing
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_empty_table();
    push_word(route_word(KIND_RESOLVE, 32'hC0A8_0001, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_FIND, '0, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_RESOLVE, '0, '0, '0, '0, 1'b1));
    push_word(route_word(KIND_UNUSED, '1, '1, MAC_BCAST, MAC_BCAST, 1'b1));
    wait_for_answers();
  endtask

  task automatic test_directed_routes();
    logic [MAC_W-1:0] mac_a;
    mac_a = 48'h0A0B_0C0D_0E0F;
    // Default route, host route, then overlapping /8 and /16 networks.
    push_word(route_word(KIND_UPDATE, '0, '0, '0, MAC_BCAST, 1'b0));
    push_word(route_word(KIND_UPDATE, '1, '1, MAC_BCAST, '0, 1'b0));
    push_word(route_word(KIND_UPDATE, 32'h0A00_0000, 32'hFF00_0000, mac_a,
                         48'h1111_2222_3333, 1'b0));
    push_word(route_word(KIND_UPDATE, 32'h0A01_0000, 32'hFFFF_0000, mac_a,
                         48'h4444_5555_6666, 1'b0));
    push_word(route_word(KIND_UPDATE, 32'h0A02_0000, 32'hFFFF_0000, 48'h1234_5678_9ABC,
                         48'h7777_8888_9999, 1'b1));
    // Same address and mask: new MACs in place.
    push_word(route_word(KIND_UPDATE, 32'h0A00_0000, 32'hFF00_0000, 48'hDDDD_0000_DDDD,
                         48'hAAAA_BBBB_CCCC, 1'b0));
    // Same address with another mask, and another address in the same /16.
    push_word(route_word(KIND_UPDATE, 32'h0A00_0000, 32'hFFFF_0000, 48'h0000_0000_0001,
                         48'h0000_0000_0002, 1'b0));
    push_word(route_word(KIND_UPDATE, 32'h0A01_00FF, 32'hFFFF_0000, mac_a,
                         48'hFEDC_BA98_7654, 1'b0));
    push_word(route_word(KIND_RESOLVE, 32'h0A01_1234, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_RESOLVE, 32'h0A7F_0001, '1, '1, '1, 1'b0));
    push_word(route_word(KIND_RESOLVE, 32'hC0A8_0001, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_RESOLVE, '1, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_RESOLVE, '0, '0, '0, '0, 1'b1));
    push_word(route_word(KIND_FIND, '0, '0, mac_a, '0, 1'b0));
    push_word(route_word(KIND_FIND, '0, '0, MAC_BCAST, '0, 1'b0));
    push_word(route_word(KIND_FIND, '1, '1, '0, '1, 1'b1));
    push_word(route_word(KIND_FIND, '0, '0, 48'h5A5A_5A5A_5A5A, '0, 1'b0));
    // A mask that is not a contiguous prefix.
    push_word(route_word(KIND_UPDATE, 32'h1234_5678, 32'hF0F0_F0F0, 48'h0F0F_0F0F_0F0F,
                         48'hF0F0_F0F0_F0F0, 1'b0));
    push_word(route_word(KIND_RESOLVE, 32'h1A3B_5C7D, '0, '0, '0, 1'b0));
    push_word(route_word(KIND_UNUSED, 32'h0A01_1234, '0, mac_a, '0, 1'b0));
    wait_for_answers();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) push_word(random_route_word());
    wait_for_answers();
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    repeat (12) push_word(random_route_word());
    wait_for_answers();
  endtask

  task automatic test_table_full();
    while (route_total < TABLE_DEPTH) push_word(fresh_route_word());
    repeat (3) push_word(fresh_route_word());
    // An exact match still succeeds on a full table.
    push_word(route_word(KIND_UPDATE, shadow_addr[0], shadow_mask[0], any_mac(),
                         any_mac(), 1'b0));
    push_word(route_word(KIND_RESOLVE, shadow_addr[TABLE_DEPTH-1], '0, '0, '0, 1'b0));
    push_word(route_word(KIND_FIND, '0, '0, shadow_station[TABLE_DEPTH-1], '0, 1'b0));
    wait_for_answers();
  endtask

  initial begin : run_tests
    foreach (net_base[j]) net_base[j] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_routes();
    test_random_traffic(200);
    test_backpressure();
    test_table_full();
    test_random_traffic(220);

    // The closing stretch runs without any idling on either side.
    gaps_on = 1'b0;
    test_random_traffic(80);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      note_fault($sformatf("%0d result words never arrived", answer_q.size()));
    end
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rtpm_pkg.sv
src/rtpm_table_mem.sv
src/rtpm_ctrl.sv
src/route_table_prefix_match.sv
bench/tb_top.sv
